// ----- rtl/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mbrpl_pkg.sv -----
// ============================================================================
// MBR partition lookup package
// Item types, entry layout, result codes and sector layout constants.
// ============================================================================
package mbrpl_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       sector_first;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] read_sector;
        logic [40:0] byte_offset;
        logic [40:0] byte_length;
    } out_item_t;

    // Byte lane 0 is the system byte, lanes 1-4 the start, lanes 5-8 the count.
    typedef struct packed {
        logic [31:0] count;
        logic [31:0] start;
        logic [7:0]  sys;
    } entry_t;

    localparam int ENTRY_LANES = 9;
    localparam int ENTRY_DEPTH = 8;

    typedef struct packed {
        logic       en;
        logic [2:0] addr;
        logic [3:0] lane;
        logic [7:0] data;
    } ram_wr_t;

    localparam logic [1:0] KIND_FOUND  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_BADSIG = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [8:0] TABLE_START = 9'd446;
    localparam logic [8:0] TABLE_LAST  = 9'd509;
    localparam logic [8:0] SIG_HI_POS  = 9'd510;
    localparam logic [8:0] SECTOR_LAST = 9'd511;

    localparam logic [7:0] SIG_HI      = 8'h55;
    localparam logic [7:0] SIG_LO      = 8'haa;
    localparam logic [7:0] SYS_EXT_CHS = 8'h05;
    localparam logic [7:0] SYS_EXT_LBA = 8'h0f;

    localparam logic [3:0] OFF_SYS        = 4'd4;
    localparam logic [3:0] OFF_START_LAST = 4'd11;
    localparam logic [3:0] OFF_COUNT      = 4'd12;
    localparam logic [3:0] LANE_START     = 4'd1;
    localparam logic [3:0] LANE_COUNT     = 4'd5;

endpackage

// ----- rtl/mbrpl_entry_ram.sv -----
// ============================================================================
// MBR partition entry RAM
// Eight partition entries of nine byte lanes, byte-wide writes, registered read.
// ============================================================================
module mbrpl_entry_ram (
    input  logic             aclk,
    input  mbrpl_pkg::ram_wr_t wr,
    input  logic             rd_en,
    input  logic [2:0]       rd_addr,
    output mbrpl_pkg::entry_t  rd_data
);
    import mbrpl_pkg::*;

    logic [ENTRY_LANES-1:0][7:0] mem [ENTRY_DEPTH];
    logic [ENTRY_LANES-1:0][7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr][wr.lane] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = entry_t'(rd_data_reg);

endmodule

// ----- rtl/mbr_partition_lookup.sv -----
// ============================================================================
// MBR partition lookup
// Finds one partition in a boot record streamed as bytes, with one level of
// extended boot sector.
// ============================================================================
// Sector bytes are taken one per cycle while input is not held off. The partition
// entries are kept in an eight-entry RAM (four boot record entries, four extended
// entries) with a registered read. After byte 511 of a boot record with a valid
// signature, or of an extended sector, the entry walk runs and input is held off:
// each entry examined takes a read and an evaluate step, for the boot record, then
// an extended sector and the boot record entries after it, then a read step reports
// not found if none matched. A result waits in an output register while the next
// sector streams in; only its byte 511 waits for that result to be taken.
module mbr_partition_lookup (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [4:0]            cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mbrpl_pkg::in_item_t   s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mbrpl_pkg::out_item_t  m_item
);
    import mbrpl_pkg::*;
    `include "assert_macros.svh"

    localparam logic [1:0] PHASE_BOOT = 2'd0;
    localparam logic [1:0] PHASE_EXT  = 2'd1;
    localparam logic [1:0] PHASE_DONE = 2'd2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0]  seq_reg, seq_next;
    logic [1:0]  phase_reg, phase_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [7:0]  sig_hi_reg, sig_hi_next;
    logic [2:0]  pidx_reg, pidx_next;
    logic [4:0]  ext_base_reg, ext_base_next;
    logic [1:0]  ext_j_reg, ext_j_next;
    logic        walk_ext_reg, walk_ext_next;
    logic [4:0]  target_reg;
    logic        m_valid_reg;
    out_item_t   m_item_reg;

    logic        accept;
    logic [1:0]  eff_phase;
    logic [8:0]  pos;
    logic [8:0]  rel;
    logic [3:0]  off;
    logic        emit;
    out_item_t   emit_item;
    ram_wr_t     wr;
    logic        rd_en;
    logic [2:0]  rd_addr;
    entry_t      ent;
    logic        skip;
    logic [5:0]  ext_number;
    logic        no_source;

    mbrpl_entry_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ent)
    );

    assign s_ready = (seq_reg == S_IDLE) && !(m_valid_reg && byte_count_reg == SECTOR_LAST);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign rd_en      = (seq_reg == S_READ);
    assign rd_addr    = walk_ext_reg ? {1'b1, ext_j_reg} : {1'b0, pidx_reg[1:0]};
    assign skip       = (ent.sys == 8'd0) || (ent.count == 32'd0);
    assign ext_number = {1'b0, ext_base_reg} + {4'd0, ext_j_reg} + 6'd1;
    assign eff_phase  = (s_item.sector_first && phase_reg >= PHASE_DONE) ? PHASE_BOOT
                                                                         : phase_reg;
    assign pos        = s_item.sector_first ? 9'd0 : byte_count_reg;
    assign rel        = pos - TABLE_START;
    assign off        = rel[3:0];
    assign no_source  = (seq_reg == S_IDLE) && !(accept && pos == SECTOR_LAST);

    always_comb begin
        seq_next        = seq_reg;
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        sig_hi_next     = sig_hi_reg;
        pidx_next       = pidx_reg;
        ext_base_next   = ext_base_reg;
        ext_j_next      = ext_j_reg;
        walk_ext_next   = walk_ext_reg;
        emit            = 1'b0;
        emit_item       = '0;
        wr              = '0;

        if (accept && (s_item.sector_first || phase_reg < PHASE_DONE)) begin
            if (s_item.sector_first && phase_reg >= PHASE_DONE) begin
                phase_next    = PHASE_BOOT;
                pidx_next     = 3'd0;
                ext_base_next = 5'd4;
            end
            byte_count_next = pos + 9'd1;

            if (pos inside {[TABLE_START:TABLE_LAST]}) begin
                wr.addr = {eff_phase == PHASE_EXT, rel[5:4]};
                wr.data = s_item.data_byte;
                if (off == OFF_SYS) begin
                    wr.en   = 1'b1;
                    wr.lane = 4'd0;
                end else if (off inside {[4'd8:OFF_START_LAST]}) begin
                    wr.en   = 1'b1;
                    wr.lane = LANE_START + {2'b00, off[1:0]};
                end else if (off >= OFF_COUNT) begin
                    wr.en   = 1'b1;
                    wr.lane = LANE_COUNT + {2'b00, off[1:0]};
                end
            end

            if (eff_phase == PHASE_BOOT && pos == SIG_HI_POS) begin
                sig_hi_next = s_item.data_byte;
            end

            if (pos == SECTOR_LAST) begin
                if (eff_phase == PHASE_BOOT) begin
                    if (sig_hi_reg != SIG_HI || s_item.data_byte != SIG_LO) begin
                        emit                  = 1'b1;
                        emit_item.result_kind = KIND_BADSIG;
                        phase_next            = PHASE_DONE;
                    end else begin
                        pidx_next     = 3'd0;
                        walk_ext_next = 1'b0;
                        seq_next      = S_READ;
                    end
                end else begin
                    walk_ext_next = 1'b1;
                    ext_j_next    = 2'd0;
                    seq_next      = S_READ;
                end
            end
        end

        case (seq_reg)
            S_READ: begin
                if (!walk_ext_reg && pidx_reg[2]) begin
                    emit                  = 1'b1;
                    emit_item.result_kind = KIND_NONE;
                    phase_next            = PHASE_DONE;
                    seq_next              = S_IDLE;
                end else begin
                    seq_next = S_EVAL;
                end
            end
            S_EVAL: begin
                seq_next = S_READ;
                if (!walk_ext_reg) begin
                    if (skip) begin
                        pidx_next = pidx_reg + 3'd1;
                    end else if (ent.sys == SYS_EXT_CHS || ent.sys == SYS_EXT_LBA) begin
                        emit                  = 1'b1;
                        emit_item.result_kind = KIND_READ;
                        emit_item.read_sector = ent.start;
                        phase_next            = PHASE_EXT;
                        seq_next              = S_IDLE;
                    end else if ({2'b00, pidx_reg} + 5'd1 == target_reg) begin
                        emit                  = 1'b1;
                        emit_item.result_kind = KIND_FOUND;
                        emit_item.byte_offset = {ent.start, 9'd0};
                        emit_item.byte_length = {ent.count, 9'd0};
                        phase_next            = PHASE_DONE;
                        seq_next              = S_IDLE;
                    end else begin
                        pidx_next = pidx_reg + 3'd1;
                    end
                end else begin
                    if (!skip && ext_number == {1'b0, target_reg}) begin
                        emit                  = 1'b1;
                        emit_item.result_kind = KIND_FOUND;
                        emit_item.byte_offset = {ent.start, 9'd0};
                        emit_item.byte_length = {ent.count, 9'd0};
                        phase_next            = PHASE_DONE;
                        seq_next              = S_IDLE;
                    end else if (ext_j_reg == 2'd3) begin
                        ext_base_next = ext_base_reg + 5'd4;
                        pidx_next     = pidx_reg + 3'd1;
                        walk_ext_next = 1'b0;
                    end else begin
                        ext_j_next = ext_j_reg + 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= S_IDLE;
            phase_reg      <= PHASE_BOOT;
            byte_count_reg <= 9'd0;
            sig_hi_reg     <= 8'd0;
            pidx_reg       <= 3'd0;
            ext_base_reg   <= 5'd4;
            ext_j_reg      <= 2'd0;
            walk_ext_reg   <= 1'b0;
            target_reg     <= 5'd1;
            m_valid_reg    <= 1'b0;
        end else begin
            seq_reg        <= seq_next;
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            sig_hi_reg     <= sig_hi_next;
            pidx_reg       <= pidx_next;
            ext_base_reg   <= ext_base_next;
            ext_j_reg      <= ext_j_next;
            walk_ext_reg   <= walk_ext_next;
            if (cfg_wr_en) begin
                target_reg <= cfg_wr_data;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_item_reg <= emit_item;
        end
    end

    // A walk only starts with the output register empty, so no result is overwritten.
    `ASSERT_SAME(a_walk_out_empty, seq_reg != S_IDLE, !m_valid_reg, "walk with result pending")
    // The primary walk never runs past the end of the table.
    `ASSERT_SAME(a_pidx_range, 1'b1, pidx_reg <= 3'd4, "primary index out of range")
    // A new result appears only after a last sector byte or a walk step.
    `ASSERT_NEXT(a_emit_source, !m_valid_reg && no_source, !m_valid_reg, "stray result")

endmodule
